/* hdl/png_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// png_pkg: shared types and constants for the peak normalizer
// Payload structs, opcodes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
package png_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 12;
   localparam int SAMPLE_W           = 16;
   localparam int PEAK_W             = 15;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_OFFSET  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_FLOOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_CEILING = 2'd2;

   typedef enum logic [1:0] {
      OP_MEASURE = 2'd0,
      OP_SCALE   = 2'd1,
      OP_CLEAR   = 2'd2
   } opcode_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic signed [SAMPLE_W-1:0]  sample_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  sample_out;
      logic                        clipped;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CLAMP,
      ST_MULT,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic measure;    // apply incoming sample to the peak
      logic clear;      // peak back to one
      logic capture;    // latch the scale sample
      logic div_start;  // load divider
      logic div_step;   // one quotient bit
      logic clamp;      // register clamped gain
      logic mult;       // register product
      logic out_load;   // load result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic quot_valid; // cached quotient matches current peak
      logic div_last;   // divider is on its final bit
   } ctrl_status_type;

endpackage

/* hdl/png_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// png_ctrl: sequencing state machine
// Accepts requests in idle, runs divide/clamp/multiply/saturate for scale
// requests (no divide on a cached quotient) and owns the result valid flag.
// ============================================================================
module png_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  png_pkg::opcode_type       req_opcode,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output png_pkg::ctrl_cmd_type     cmd,
   input  png_pkg::ctrl_status_type  status
);

   png_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= png_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         png_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  png_pkg::OP_MEASURE: cmd.measure = 1'b1;
                  png_pkg::OP_CLEAR:   cmd.clear   = 1'b1;
                  png_pkg::OP_SCALE: begin
                     cmd.capture = 1'b1;
                     if (status.quot_valid) begin
                        state_in = png_pkg::ST_CLAMP;
                     end else begin
                        cmd.div_start = 1'b1;
                        state_in      = png_pkg::ST_DIVIDE;
                     end
                  end
                  default: ; // unused opcode: dropped
               endcase
            end
         end
         png_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = png_pkg::ST_CLAMP;
            end
         end
         png_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = png_pkg::ST_MULT;
         end
         png_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = png_pkg::ST_SAT;
         end
         png_pkg::ST_SAT: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = png_pkg::ST_IDLE;
            end
         end
         default: state_in = png_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/png_dpath.sv */
`timescale 1ns / 1ps
// ============================================================================
// png_dpath: peak, gain and scaling datapath
// Config registers, peak tracker, restoring divider with cached quotient,
// gain clamp, multiplier and output saturation.
// ============================================================================
module png_dpath #(
   parameter int GAIN_FRAC_BITS = png_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [png_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [png_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  png_pkg::req_payload_type            req_payload,
   output png_pkg::rsp_payload_type            rsp_payload,
   input  png_pkg::ctrl_cmd_type               cmd,
   output png_pkg::ctrl_status_type            status
);

   localparam int QW     = png_pkg::PEAK_W + GAIN_FRAC_BITS;   // quotient width
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int GW     = png_pkg::CSR_DATA_W;                 // gain width
   localparam int MAG_W  = png_pkg::SAMPLE_W + 1;
   localparam int PROD_W = MAG_W + GW;
   localparam int QOUT_W = PROD_W - GAIN_FRAC_BITS;
   localparam int OFS_RAW  = (6 * (1 << GAIN_FRAC_BITS) + 5) / 10;
   localparam int FLR_RAW  = 1 << GAIN_FRAC_BITS;
   localparam int CEIL_RAW = (18 * (1 << GAIN_FRAC_BITS) + 5) / 10;
   localparam logic [GW-1:0] OFS_RST  = (OFS_RAW  > 65535) ? 16'hffff : GW'(OFS_RAW);
   localparam logic [GW-1:0] FLR_RST  = (FLR_RAW  > 65535) ? 16'hffff : GW'(FLR_RAW);
   localparam logic [GW-1:0] CEIL_RST = (CEIL_RAW > 65535) ? 16'hffff : GW'(CEIL_RAW);
   localparam logic [QW-1:0] DIVIDEND = {15'h7fff, {GAIN_FRAC_BITS{1'b0}}};

   // ---- configuration -----------------------------------------------------
   logic [GW-1:0] offset_ff, floor_ff, ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= OFS_RST;
         floor_ff   <= FLR_RST;
         ceiling_ff <= CEIL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            png_pkg::CSR_GAIN_OFFSET:  offset_ff  <= csr_wdata;
            png_pkg::CSR_GAIN_FLOOR:   floor_ff   <= csr_wdata;
            png_pkg::CSR_GAIN_CEILING: ceiling_ff <= csr_wdata;
            default: ; // no register there
         endcase
      end
   end

   // ---- peak tracking -----------------------------------------------------
   logic [png_pkg::PEAK_W-1:0] peak_ff, peak_in;
   logic                       quot_valid_ff, quot_valid_in;
   logic                       peak_raise;

   assign peak_raise = !req_payload.sample_in[15] &&
                       (req_payload.sample_in[14:0] > peak_ff);

   always_comb begin
      peak_in       = peak_ff;
      quot_valid_in = quot_valid_ff;
      if (cmd.clear) begin
         peak_in       = png_pkg::PEAK_W'(1);
         quot_valid_in = 1'b0;
      end else if (cmd.measure && peak_raise) begin
         peak_in       = req_payload.sample_in[14:0];
         quot_valid_in = 1'b0;
      end else if (cmd.div_step && status.div_last) begin
         quot_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff       <= png_pkg::PEAK_W'(1);
         quot_valid_ff <= 1'b0;
      end else begin
         peak_ff       <= peak_in;
         quot_valid_ff <= quot_valid_in;
      end
   end

   // ---- restoring divider: one quotient bit a cycle ----------------------
   logic [QW-1:0]              quot_ff;
   logic [png_pkg::PEAK_W-1:0] rem_ff;
   logic [CNT_W-1:0]           div_cnt_ff;
   logic [png_pkg::PEAK_W-1:0] divisor;
   logic [png_pkg::PEAK_W:0]   rem_shift;
   logic [png_pkg::PEAK_W+1:0] trial;

   assign divisor   = (peak_ff == '0) ? png_pkg::PEAK_W'(1) : peak_ff;
   assign rem_shift = {rem_ff, quot_ff[QW-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= CNT_W'(QW);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quot_ff <= DIVIDEND;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[QW-2:0], ~trial[png_pkg::PEAK_W+1]};
         rem_ff  <= trial[png_pkg::PEAK_W+1] ? rem_shift[png_pkg::PEAK_W-1:0]
                                              : trial[png_pkg::PEAK_W-1:0];
      end
   end

   assign status.div_last   = (div_cnt_ff == CNT_W'(1));
   assign status.quot_valid = quot_valid_ff;

   // ---- gain: subtract offset, floor clamp, then ceiling clamp ------------
   logic [QW:0]   gain_diff;
   logic [QW-1:0] gain_lo;
   logic [GW-1:0] gain_ff, gain_in;

   assign gain_diff = {1'b0, quot_ff} - (QW + 1)'(offset_ff);

   always_comb begin
      if (gain_diff[QW] || (gain_diff[QW-1:0] < QW'(floor_ff))) begin
         gain_lo = QW'(floor_ff);
      end else begin
         gain_lo = gain_diff[QW-1:0];
      end
      if (gain_lo > QW'(ceiling_ff)) begin
         gain_in = ceiling_ff;
      end else begin
         gain_in = gain_lo[GW-1:0];
      end
   end

   // ---- scaling -----------------------------------------------------------
   logic signed [png_pkg::SAMPLE_W-1:0] sample_ff;
   logic [MAG_W-1:0]                    mag;
   logic [MAG_W-1:0]                    s_ext;
   logic [PROD_W-1:0]                   prod_ff;
   logic [QOUT_W-1:0]                   qout;
   logic                                neg;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_payload.sample_in;
      end
      if (cmd.clamp) begin
         gain_ff <= gain_in;
      end
      if (cmd.mult) begin
         prod_ff <= mag * PROD_W'(gain_ff);
      end
   end

   assign neg   = sample_ff[png_pkg::SAMPLE_W-1];
   assign s_ext = {sample_ff[png_pkg::SAMPLE_W-1], sample_ff};
   assign mag   = neg ? (MAG_W'(0) - s_ext) : s_ext;
   assign qout  = prod_ff[PROD_W-1:GAIN_FRAC_BITS];

   // ---- saturation and result register -----------------------------------
   png_pkg::rsp_payload_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in = '0;
      if (neg) begin
         if (qout > QOUT_W'(32768)) begin
            rsp_in.sample_out = 16'sh8000;
            rsp_in.clipped    = 1'b1;
         end else begin
            rsp_in.sample_out = 16'(16'd0 - qout[15:0]);
         end
      end else begin
         if (qout > QOUT_W'(32767)) begin
            rsp_in.sample_out = 16'sh7fff;
            rsp_in.clipped    = 1'b1;
         end else begin
            rsp_in.sample_out = qout[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* hdl/peak_normalize_gain.sv */
`timescale 1ns / 1ps
// ============================================================================
// peak_normalize_gain: peak volume normalizer with clamped gain
// Measure requests track a running positive peak; scale requests multiply
// the sample by (32767/peak in fixed point - offset), clamped to floor and
// ceiling, then truncate toward zero and saturate to 16 bits with a flag.
// ============================================================================
//
//  Channel  Ports                               Dir  Moves
//  -------  ----------------------------------  ---  --------------------------
//  request  req_valid/req_ready/req_payload     in   opcode + 16-bit sample
//  result   rsp_valid/rsp_ready/rsp_payload     out  scaled sample + clip flag
//  config   csr_we/csr_index/csr_wdata          in   offset, floor, ceiling
//
//  Measure, clear and unused opcodes: accepted in idle, no result.
//  Scale: a radix-2 divide of 15 + GAIN_FRAC_BITS quotient bits, then clamp,
//  multiply and saturate, after reset, a clear or a new peak; the divide is
//  skipped when the cached quotient is reused.
//  Reset (synchronous) puts peak at 1, config to 0.6 / 1.0 / 1.8 in Q.F.
//  A stalled result holds; measure/clear still go, a next scale waits at saturate.
//
module peak_normalize_gain #(
   parameter int GAIN_FRAC_BITS = png_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  png_pkg::req_payload_type         req_payload,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output png_pkg::rsp_payload_type         rsp_payload,
   // config writes
   input  logic                             csr_we,
   input  logic [png_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [png_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   png_pkg::ctrl_cmd_type    cmd;
   png_pkg::ctrl_status_type status;

   // sequencer: request acceptance, stage stepping, result valid
   png_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_payload.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: config, peak, divider, clamp, multiply, saturate
   png_dpath #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

/* dv/tb_peak_normalize_gain.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_peak_normalize_gain: self-checking bench for the peak normalizer
// A short table of directed requests runs at the reset gain settings. Random
// request bursts then run under six gain settings, including the extremes.
// Every scale result is checked in order against the table's expected value
// or a local model of the peak, the clamped gain and the truncate/saturate step.
// ============================================================================
module tb_peak_normalize_gain;

   localparam int FRAC_BITS       = png_pkg::GAIN_FRAC_BITS_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;  // no enum member; the block drops it
   localparam int ITEMS_PER_PHASE = 155;
   localparam int NUM_PHASES      = 6;
   localparam int SETTLE_CYCLES   = 40;      // covers a full divide+scale
   localparam int HOLD_CYCLES     = 300;     // long result back-pressure stretch
   localparam int N_DIRECTED      = 24;

   // one directed request; want_* is only used when known is set
   typedef struct packed {
      logic [1:0]          op;
      logic signed [15:0]  sample;
      logic                known;
      logic signed [15:0]  want_out;
      logic                want_clip;
   } request_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   png_pkg::req_payload_type  req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   png_pkg::rsp_payload_type  rsp_payload;
   logic             csr_we      = 1'b0;
   logic [png_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [png_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // normalizer model state and gain settings
   logic [14:0]      model_peak  = 15'd1;
   logic [15:0]      cfg_offset  = 16'd2458;
   logic [15:0]      cfg_floor   = 16'd4096;
   logic [15:0]      cfg_ceiling = 16'd7373;

   png_pkg::rsp_payload_type  scaled_samples_due [$];
   int               mismatches     = 0;
   int               requests_sent  = 0;
   int               send_idle_pct  = 17;
   int               recv_idle_pct  = 59;
   bit               hold_results   = 1'b0;

   // Directed requests. The reset gain is pinned at the 1.8 ceiling while the
   // peak is 1; with the peak at full scale the raw gain of 1.0 minus the
   // offset drops under the floor, so the gain is exactly 1.0.
   request_row_type directed_requests [N_DIRECTED] = '{
      '{png_pkg::OP_SCALE,   16'sd0,      1'b1, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   16'sd1,      1'b1, 16'sd1,      1'b0},
      '{png_pkg::OP_SCALE,   -16'sd1,     1'b1, -16'sd1,     1'b0},
      '{png_pkg::OP_SCALE,   16'sh7fff,   1'b1, 16'sh7fff,   1'b1},  // positive clip
      '{png_pkg::OP_SCALE,   16'sh8000,   1'b1, 16'sh8000,   1'b1},  // negative clip
      '{png_pkg::OP_MEASURE, 16'sh7fff,   1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   16'sh7fff,   1'b1, 16'sh7fff,   1'b0},
      '{png_pkg::OP_SCALE,   16'sh8000,   1'b1, 16'sh8000,   1'b0},  // -32768 at unity
      '{png_pkg::OP_MEASURE, 16'sh8000,   1'b0, 16'sd0,      1'b0},  // negative: peak holds
      '{png_pkg::OP_MEASURE, 16'sd0,      1'b0, 16'sd0,      1'b0},  // zero: peak holds
      '{png_pkg::OP_SCALE,   16'sh7fff,   1'b1, 16'sh7fff,   1'b0},
      '{OP_UNUSED,           16'sh5a5a,   1'b0, 16'sd0,      1'b0},
      '{OP_UNUSED,           16'sha5a5,   1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   -16'sd12345, 1'b1, -16'sd12345, 1'b0},
      '{png_pkg::OP_CLEAR,   16'sh7fff,   1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   16'sd100,    1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_MEASURE, 16'sd100,    1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_MEASURE, 16'sd50,     1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   16'sd1000,   1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   -16'sd1000,  1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_MEASURE, 16'sd16384,  1'b0, 16'sd0,      1'b0},  // gain inside clamps
      '{png_pkg::OP_SCALE,   16'sd20000,  1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_MEASURE, 16'sd20000,  1'b0, 16'sd0,      1'b0},
      '{png_pkg::OP_SCALE,   -16'sd20001, 1'b0, 16'sd0,      1'b0}
   };

   always #2 clock = ~clock;

   peak_normalize_gain dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns mismatch: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Advance the model by one accepted request; a scale request yields one
   // result. Gain is floor(32767 << F / peak) - offset, raised to the floor,
   // then lowered to the ceiling, so the ceiling wins when floor > ceiling.
   task automatic step_normalizer(input logic [1:0] op, input logic signed [15:0] smp,
                                  output bit has_rsp,
                                  output png_pkg::rsp_payload_type rsp);
      longint s;
      longint gain;
      longint mag;
      longint q;
      s       = smp;
      has_rsp = 1'b0;
      rsp     = '0;
      case (op)
         png_pkg::OP_MEASURE: begin
            if (s > longint'(model_peak))
               model_peak = smp[14:0];
         end
         png_pkg::OP_CLEAR: begin
            model_peak = 15'd1;
         end
         png_pkg::OP_SCALE: begin
            gain = (longint'(32'h7fff) << FRAC_BITS) / longint'(model_peak);
            gain = gain - longint'(cfg_offset);
            if (gain < longint'(cfg_floor))
               gain = longint'(cfg_floor);
            if (gain > longint'(cfg_ceiling))
               gain = longint'(cfg_ceiling);
            // magnitude times gain, truncated toward zero
            mag = (s < 0) ? -s : s;
            q   = (mag * gain) >>> FRAC_BITS;
            if (s < 0) begin
               if (q > 32768) begin
                  q           = 32768;
                  rsp.clipped = 1'b1;
               end
               rsp.sample_out = 16'(-q);
            end else begin
               if (q > 32767) begin
                  q           = 32767;
                  rsp.clipped = 1'b1;
               end
               rsp.sample_out = 16'(q);
            end
            has_rsp = 1'b1;
         end
         default: ;  // unused opcode: dropped, state unchanged
      endcase
   endtask

   // Offer one request, hold it until accepted, then log what it should produce.
   // Leaves valid high so back-to-back requests need no extra step.
   task automatic send_request(input request_row_type row);
      bit                       has_rsp;
      png_pkg::rsp_payload_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.opcode    <= png_pkg::opcode_type'(row.op);
      req_payload.sample_in <= row.sample;
      do @(posedge clock); while (!req_ready);
      step_normalizer(row.op, row.sample, has_rsp, predicted);
      if (has_rsp) begin
         if (row.known) begin
            predicted.sample_out = row.want_out;
            predicted.clipped    = row.want_clip;
         end
         scaled_samples_due = {scaled_samples_due, predicted};
      end
      if (row.op != OP_UNUSED)
         requests_sent++;
   endtask

   // Random sample: mostly full range, some tiny values (tiny peaks give big
   // gains and clipping), some exact extremes.
   function automatic request_row_type random_row(input logic [1:0] op);
      request_row_type r;
      r    = '0;
      r.op = op;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       r.sample = 16'sh7fff;
               1:       r.sample = 16'sh8000;
               2:       r.sample = 16'sd0;
               3:       r.sample = 16'sd1;
               default: r.sample = -16'sd1;
            endcase
         end
         1, 2:    r.sample = 16'($urandom_range(0, 511) - 256);
         default: r.sample = 16'($urandom);
      endcase
      return r;
   endfunction

   // Mostly well-formed bursts (optional clear, a few measures, then scales),
   // with the rest single random requests of any opcode.
   task automatic send_random_burst();
      int n;
      if ($urandom_range(0, 99) < 80) begin
         if ($urandom_range(0, 99) < 60)
            send_request(random_row(png_pkg::OP_CLEAR));
         n = $urandom_range(1, 4);
         repeat (n) send_request(random_row(png_pkg::OP_MEASURE));
         n = $urandom_range(1, 6);
         repeat (n) send_request(random_row(png_pkg::OP_SCALE));
      end else begin
         send_request(random_row(2'($urandom_range(0, 3))));
      end
   endtask

   task automatic write_reg(input logic [png_pkg::CSR_INDEX_W-1:0] index,
                            input logic [png_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         png_pkg::CSR_GAIN_OFFSET:  cfg_offset  = value;
         png_pkg::CSR_GAIN_FLOOR:   cfg_floor   = value;
         png_pkg::CSR_GAIN_CEILING: cfg_ceiling = value;
         default: ;
      endcase
   endtask

   task automatic program_gains(input logic [15:0] offset, input logic [15:0] lo,
                                input logic [15:0] hi);
      write_reg(png_pkg::CSR_GAIN_OFFSET, offset);
      write_reg(png_pkg::CSR_GAIN_FLOOR, lo);
      write_reg(png_pkg::CSR_GAIN_CEILING, hi);
      csr_we <= 1'b0;
   endtask

   // Stop offering, wait for every pending result, then let a measure or
   // clear still in flight finish before anything else changes.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (scaled_samples_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_result(input png_pkg::rsp_payload_type got);
      png_pkg::rsp_payload_type want;
      if (scaled_samples_due.size() == 0) begin
         report_mismatch("result with nothing pending, sample_out", got.sample_out, 0);
      end else begin
         want = scaled_samples_due.pop_front();
         if (got.sample_out !== want.sample_out)
            report_mismatch("sample_out", got.sample_out, want.sample_out);
         if (got.clipped !== want.clipped)
            report_mismatch("clipped", got.clipped, want.clipped);
      end
   endtask

   // Result side: check each accepted result, then pick next ready. A hold
   // request from the stimulus side stalls results for HOLD_CYCLES while the
   // sender keeps offering, so the block backs up and drops req_ready.
   initial begin : result_sink
      int held;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            check_result(rsp_payload);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            hold_results = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int  phase;
      bit  paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset gain settings
      for (int i = 0; i < N_DIRECTED; i++)
         send_request(directed_requests[i]);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0:       program_gains(16'd0, 16'd0, 16'hffff);      // widest gain range
            1:       program_gains(16'hffff, 16'd0, 16'hffff);   // offset swamps raw gain
            2:       program_gains(16'd0, 16'hffff, 16'd0);      // floor over ceiling
            3:       program_gains(16'($urandom), 16'($urandom), 16'($urandom));
            4:       program_gains(16'($urandom_range(0, 4096)),
                                   16'($urandom_range(2048, 6144)),
                                   16'($urandom_range(6144, 16384)));
            default: program_gains(16'd2458, 16'd4096, 16'd7373);
         endcase

         // idling: sender-light first, then receiver-light, then none
         if (phase < 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 59;
         end else if (phase < 4) begin
            send_idle_pct = 59;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 0)
            hold_results = 1'b1;

         requests_sent = 0;
         while (requests_sent < ITEMS_PER_PHASE) begin
            // once, let the block run completely dry mid-phase
            if (phase == 2 && !paused && requests_sent >= ITEMS_PER_PHASE / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (scaled_samples_due.size() != 0);
               paused = 1'b1;
            end
            send_random_burst();
         end
      end

      drain_results();
      if (mismatches == 0)
         $display("tb_peak_normalize_gain: PASS");
      else
         $display("tb_peak_normalize_gain: FAIL");
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("tb_peak_normalize_gain: FAIL");
      $finish;
   end

endmodule
